/* rtl/sdaf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the signed decimal ASCII formatter.
// No dependencies; used by every module of the block but the queue.
package sdaf_pkg;

  // Default digit store size and queue depth
  localparam int MAX_DIGITS_DEF  = 10;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Digit count field wide enough for a MAX_DIGITS of up to 31
  localparam int NDIG_W = 5;

  // Input count width, scale width and the width of the division step counter
  localparam int COUNT_W = 32;
  localparam int SCALE_W = 16;
  localparam int STEP_W  = $clog2(COUNT_W);

  // Configuration register indexes
  localparam logic CFG_SCALE_DIVISOR   = 1'b0;
  localparam logic CFG_APPEND_LINE_END = 1'b1;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_RUN,
    FR_HOLD
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SIGN,
    BK_DIGIT,
    BK_CR,
    BK_LF
  } back_state_t;

  // Control part of one formatted request
  typedef struct packed {
    logic              neg;
    logic              crlf;
    logic [NDIG_W-1:0] ndig;
  } rec_ctrl_t;

endpackage

/* rtl/sdaf_front.sv */
`timescale 1ns / 1ps
// Front end: accepts a count, divides its magnitude by the scale and converts
// the quotient to BCD in one shared bit-serial loop. Depends on sdaf_pkg.
module sdaf_front #(
  parameter int MAX_DIGITS = sdaf_pkg::MAX_DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [sdaf_pkg::COUNT_W-1:0] in_count_value,
  input  logic        [sdaf_pkg::SCALE_W-1:0] scale_divisor,
  input  logic                                append_line_end,
  output logic                                rec_valid,
  input  logic                                rec_ready,
  output sdaf_pkg::rec_ctrl_t                 rec_ctrl,
  output logic        [4*MAX_DIGITS-1:0]      rec_digits
);

  localparam int BCD_W = 4 * MAX_DIGITS;

  sdaf_pkg::front_state_t state_r, state_nxt;

  logic [sdaf_pkg::COUNT_W-1:0] mag_r, mag_nxt;
  logic [sdaf_pkg::SCALE_W-1:0] rem_r, rem_nxt;
  logic [sdaf_pkg::SCALE_W-1:0] div_r, div_nxt;
  logic [BCD_W-1:0]             bcd_r, bcd_nxt;
  logic                         ovf_r, ovf_nxt;
  logic                         neg_r, neg_nxt;
  logic                         crlf_r, crlf_nxt;
  logic [sdaf_pkg::STEP_W-1:0]  step_r, step_nxt;

  logic [sdaf_pkg::SCALE_W:0]   trial;
  logic                         qbit;
  logic [BCD_W-1:0]             adj;
  logic [sdaf_pkg::NDIG_W-1:0]  ndig;
  logic                         is_zero;

  // Restoring division step: quotient bit comes out most significant first
  always_comb begin
    trial = {rem_r, mag_r[sdaf_pkg::COUNT_W-1]};
    qbit  = (trial >= {1'b0, div_r});
  end

  // Double-dabble adjust on every digit before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
    end
  end

  // Digit count: highest non-zero digit, at least one, all of them on overflow
  always_comb begin
    ndig = sdaf_pkg::NDIG_W'(1);
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        ndig = sdaf_pkg::NDIG_W'(i + 1);
      end
    end
    if (ovf_r) begin
      ndig = sdaf_pkg::NDIG_W'(MAX_DIGITS);
    end
    is_zero = !ovf_r && (bcd_r == '0);
  end

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    bcd_nxt   = bcd_r;
    ovf_nxt   = ovf_r;
    neg_nxt   = neg_r;
    crlf_nxt  = crlf_r;
    step_nxt  = step_r;
    case (state_r)
      sdaf_pkg::FR_IDLE: begin
        if (in_push) begin
          neg_nxt   = in_count_value[sdaf_pkg::COUNT_W-1];
          mag_nxt   = in_count_value[sdaf_pkg::COUNT_W-1] ?
                      (~in_count_value + 1'b1) : in_count_value;
          div_nxt   = (scale_divisor == '0) ? sdaf_pkg::SCALE_W'(1) : scale_divisor;
          crlf_nxt  = append_line_end;
          rem_nxt   = '0;
          bcd_nxt   = '0;
          ovf_nxt   = 1'b0;
          step_nxt  = '0;
          state_nxt = sdaf_pkg::FR_RUN;
        end
      end
      sdaf_pkg::FR_RUN: begin
        rem_nxt  = qbit ? sdaf_pkg::SCALE_W'(trial - {1'b0, div_r})
                        : trial[sdaf_pkg::SCALE_W-1:0];
        mag_nxt  = {mag_r[sdaf_pkg::COUNT_W-2:0], 1'b0};
        ovf_nxt  = ovf_r | adj[BCD_W-1];
        bcd_nxt  = {adj[BCD_W-2:0], qbit};
        step_nxt = step_r + 1'b1;
        if (step_r == sdaf_pkg::STEP_W'(sdaf_pkg::COUNT_W - 1)) begin
          state_nxt = sdaf_pkg::FR_HOLD;
        end
      end
      sdaf_pkg::FR_HOLD: begin
        if (rec_ready) begin
          state_nxt = sdaf_pkg::FR_IDLE;
        end
      end
      default: begin
        state_nxt = sdaf_pkg::FR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdaf_pkg::FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    bcd_r  <= bcd_nxt;
    ovf_r  <= ovf_nxt;
    neg_r  <= neg_nxt;
    crlf_r <= crlf_nxt;
    step_r <= step_nxt;
  end

  assign in_full       = (state_r != sdaf_pkg::FR_IDLE);
  assign rec_valid     = (state_r == sdaf_pkg::FR_HOLD);
  assign rec_ctrl.neg  = neg_r && !is_zero;
  assign rec_ctrl.crlf = crlf_r;
  assign rec_ctrl.ndig = ndig;
  assign rec_digits    = bcd_r;

endmodule

/* rtl/sdaf_queue.sv */
`timescale 1ns / 1ps
// Short register queue between the front and back ends.
// Depends on nothing beyond its parameters.
module sdaf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/sdaf_back.sv */
`timescale 1ns / 1ps
// Back end: serialises one formatted request into characters, one a cycle while
// the consumer keeps popping, through a registered output stage. Depends on sdaf_pkg.
module sdaf_back #(
  parameter int MAX_DIGITS = sdaf_pkg::MAX_DIGITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    rec_valid,
  output logic                    rec_pop,
  input  sdaf_pkg::rec_ctrl_t     rec_ctrl,
  input  logic [4*MAX_DIGITS-1:0] rec_digits,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [7:0]              out_ascii_char,
  output logic                    out_last_char
);

  localparam int DIDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  sdaf_pkg::back_state_t state_r, state_nxt;

  logic [4*MAX_DIGITS-1:0]     dig_r, dig_nxt;
  logic                        crlf_r, crlf_nxt;
  logic [DIDX_W-1:0]           idx_r, idx_nxt;
  logic                        ovld_r, ovld_nxt;
  logic [7:0]                  char_r, char_nxt;
  logic                        last_r, last_nxt;
  logic                        can_emit;
  logic [sdaf_pkg::NDIG_W-1:0] ndig_m1;
  logic [3:0]                  cur_dig;

  assign can_emit = !ovld_r || out_pop;
  assign ndig_m1  = rec_ctrl.ndig - sdaf_pkg::NDIG_W'(1);
  assign cur_dig  = dig_r[4*idx_r +: 4];

  always_comb begin
    state_nxt = state_r;
    dig_nxt   = dig_r;
    crlf_nxt  = crlf_r;
    idx_nxt   = idx_r;
    ovld_nxt  = ovld_r && !out_pop;
    char_nxt  = char_r;
    last_nxt  = last_r;
    rec_pop   = 1'b0;
    case (state_r)
      sdaf_pkg::BK_IDLE: begin
        if (rec_valid) begin
          rec_pop   = 1'b1;
          dig_nxt   = rec_digits;
          crlf_nxt  = rec_ctrl.crlf;
          idx_nxt   = ndig_m1[DIDX_W-1:0];
          state_nxt = rec_ctrl.neg ? sdaf_pkg::BK_SIGN : sdaf_pkg::BK_DIGIT;
        end
      end
      sdaf_pkg::BK_SIGN: begin
        if (can_emit) begin
          ovld_nxt  = 1'b1;
          char_nxt  = sdaf_pkg::CH_MINUS;
          last_nxt  = 1'b0;
          state_nxt = sdaf_pkg::BK_DIGIT;
        end
      end
      sdaf_pkg::BK_DIGIT: begin
        if (can_emit) begin
          ovld_nxt = 1'b1;
          char_nxt = sdaf_pkg::CH_ZERO + {4'd0, cur_dig};
          last_nxt = (idx_r == '0) && !crlf_r;
          if (idx_r == '0) begin
            state_nxt = crlf_r ? sdaf_pkg::BK_CR : sdaf_pkg::BK_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      sdaf_pkg::BK_CR: begin
        if (can_emit) begin
          ovld_nxt  = 1'b1;
          char_nxt  = sdaf_pkg::CH_CR;
          last_nxt  = 1'b0;
          state_nxt = sdaf_pkg::BK_LF;
        end
      end
      sdaf_pkg::BK_LF: begin
        if (can_emit) begin
          ovld_nxt  = 1'b1;
          char_nxt  = sdaf_pkg::CH_LF;
          last_nxt  = 1'b1;
          state_nxt = sdaf_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = sdaf_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdaf_pkg::BK_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r  <= dig_nxt;
    crlf_r <= crlf_nxt;
    idx_r  <= idx_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_empty      = !ovld_r;
  assign out_ascii_char = char_r;
  assign out_last_char  = last_r;

endmodule

/* rtl/signed_decimal_ascii_formatter_unit.sv */
`timescale 1ns / 1ps
// Signed decimal ASCII formatter. Each count pushed in is divided by the
// scale register (truncating toward zero; a scale of 0 acts as 1) and its
// quotient comes out as ASCII characters, one per pop: '-' for a negative
// non-zero quotient, the decimal digits most significant first with no
// leading zeros ('0' for zero), then CR LF when append_line_end is set; the
// final character of each request carries out_last_char. The front end works
// on one request at a time in one shared bit-serial loop that does the restoring
// division and the binary-to-BCD conversion together, then hands the result
// over and goes back to idle before it takes a new count. A two-entry queue
// sits between it and the back end, which emits one character a cycle
// (1 to 13 per request) through an output register while the consumer keeps
// popping, so the output side never throttles the front unless the consumer
// stalls. Write configuration only while idle. No clearing pass is needed
// after reset. Depends on sdaf_pkg, sdaf_front, sdaf_queue and sdaf_back.
module signed_decimal_ascii_formatter_unit #(
  parameter int MAX_DIGITS  = sdaf_pkg::MAX_DIGITS_DEF,
  parameter int QUEUE_DEPTH = sdaf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input request channel
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [sdaf_pkg::COUNT_W-1:0] in_count_value,
  // result channel
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic        [7:0]                   out_ascii_char,
  output logic                                out_last_char,
  // configuration write port
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic        [sdaf_pkg::SCALE_W-1:0] cfg_wdata
);

  localparam int REC_W = $bits(sdaf_pkg::rec_ctrl_t) + 4 * MAX_DIGITS;

  logic [sdaf_pkg::SCALE_W-1:0] scale_r;
  logic                         line_end_r;

  logic                    f_valid;
  logic                    q_full;
  logic                    q_empty;
  logic                    q_pop;
  sdaf_pkg::rec_ctrl_t     f_ctrl;
  logic [4*MAX_DIGITS-1:0] f_digits;
  logic [REC_W-1:0]        q_rd;
  sdaf_pkg::rec_ctrl_t     b_ctrl;
  logic [4*MAX_DIGITS-1:0] b_digits;

  // Configuration registers: hold until written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r    <= sdaf_pkg::SCALE_W'(1);
      line_end_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sdaf_pkg::CFG_SCALE_DIVISOR:   scale_r    <= cfg_wdata;
        sdaf_pkg::CFG_APPEND_LINE_END: line_end_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept, take the magnitude, divide and convert
  sdaf_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_count_value  (in_count_value),
    .scale_divisor   (scale_r),
    .append_line_end (line_end_r),
    .rec_valid       (f_valid),
    .rec_ready       (!q_full),
    .rec_ctrl        (f_ctrl),
    .rec_digits      (f_digits)
  );

  // Queue of formatted requests between the two halves
  sdaf_queue #(
    .WIDTH(REC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_data ({f_ctrl, f_digits}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rd),
    .empty     (q_empty)
  );

  assign {b_ctrl, b_digits} = q_rd;

  // Back: serialise characters into the output register
  sdaf_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .rec_valid      (!q_empty),
    .rec_pop        (q_pop),
    .rec_ctrl       (b_ctrl),
    .rec_digits     (b_digits),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_ascii_char (out_ascii_char),
    .out_last_char  (out_last_char)
  );

`ifndef SYNTHESIS
  // Back end takes a request only when one is queued
  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back end popped an empty queue");

  // An accepted count keeps the front busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> in_full)
    else $error("front end not busy after accepting a count");

  // A zero quotient never carries a sign
  a_zero_unsigned: assert property (@(posedge clk) disable iff (!rst_n)
    (f_valid && (f_digits == '0) && (f_ctrl.ndig == 5'd1)) |-> !f_ctrl.neg)
    else $error("signed zero handed to the queue");
`endif

endmodule

/* tb/sv/tb_signed_decimal_ascii_formatter_unit.sv */
`timescale 1ns / 1ps
// Self-checking bench for signed_decimal_ascii_formatter_unit: a directed table
// then random phases, checked against typed text or an in-bench formatter model.
// Depends on sdaf_pkg and the RTL of the block.
module tb_signed_decimal_ascii_formatter_unit;

  // Digit store of the default build
  localparam int NUM_DIGITS   = sdaf_pkg::MAX_DIGITS_DEF;
  localparam int DIR_ROWS     = 25;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 38;
  localparam int HOLD_CYCLES  = 600;
  // Wait after the drain before the final check; allow a margin
  localparam int TAIL_CYCLES  = 80;
  localparam int MAX_PRINTED  = 60;

  // One expected character of the result stream
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_exp_t;

  // One row of the directed table: a register write or a request. A
  // non-zero text holds the expected characters, right-aligned.
  typedef struct packed {
    logic                         is_cfg;
    logic                         idx;
    logic [sdaf_pkg::SCALE_W-1:0] val;
    logic [sdaf_pkg::COUNT_W-1:0] count;
    logic [87:0]                  text;
  } dir_row_t;

  logic                               clk;
  logic                               rst_n;
  logic                               in_push;
  logic                               in_full;
  logic signed [sdaf_pkg::COUNT_W-1:0] in_count_value;
  logic                               out_empty;
  logic                               out_pop;
  logic [7:0]                         out_ascii_char;
  logic                               out_last_char;
  logic                               cfg_we;
  logic                               cfg_index;
  logic [sdaf_pkg::SCALE_W-1:0]       cfg_wdata;

  // Shadow copy of the registers, as the formatter model sees them
  logic [sdaf_pkg::SCALE_W-1:0] scale_shadow;
  logic                         crlf_shadow;

  char_exp_t pending_chars[$];
  int        mismatch_count;
  int        chars_taken;
  int        tx_gap_max;
  bit        hold_wanted;
  bit        hold_done;
  dir_row_t  dir_tab[DIR_ROWS];

  signed_decimal_ascii_formatter_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_count_value (in_count_value),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_ascii_char (out_ascii_char),
    .out_last_char  (out_last_char),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) begin
      $display("MISMATCH (result %0d): %s", chars_taken, msg);
    end
    mismatch_count++;
  endtask

  // Format one count as the block should: divide by the scale (0 acts
  // as 1), truncate toward zero, sign only for a non-zero negative
  // quotient, then digits most significant first, then CR LF if enabled.
  function automatic void predict_chars(input logic [sdaf_pkg::COUNT_W-1:0] raw);
    logic                         neg;
    logic [sdaf_pkg::COUNT_W-1:0] mag;
    logic [sdaf_pkg::COUNT_W-1:0] divisor;
    logic [3:0]                   digs[$];
    logic [7:0]                   line[$];
    char_exp_t                    e;
    neg     = raw[sdaf_pkg::COUNT_W-1];
    mag     = neg ? (~raw + 1'b1) : raw;
    divisor = (scale_shadow == '0) ? sdaf_pkg::COUNT_W'(1)
                                   : sdaf_pkg::COUNT_W'(scale_shadow);
    mag     = mag / divisor;
    if (mag == '0) begin
      // A negative count that truncates to zero prints no sign
      neg = 1'b0;
      digs.push_back(4'd0);
    end else begin
      // Drop digits beyond the store; the default store holds any count
      while (mag != '0 && digs.size() < NUM_DIGITS) begin
        digs.push_back(4'(mag % 10));
        mag = mag / 10;
      end
    end
    if (neg) line.push_back(sdaf_pkg::CH_MINUS);
    for (int i = digs.size() - 1; i >= 0; i--) begin
      line.push_back(sdaf_pkg::CH_ZERO + 8'(digs[i]));
    end
    if (crlf_shadow) begin
      line.push_back(sdaf_pkg::CH_CR);
      line.push_back(sdaf_pkg::CH_LF);
    end
    foreach (line[i]) begin
      e.ch   = line[i];
      e.last = (i == line.size() - 1);
      pending_chars.push_back(e);
    end
  endfunction

  // Queue the characters typed into a table row, skipping the padding
  function automatic void expect_text(input logic [87:0] text);
    logic [7:0] line[$];
    char_exp_t  e;
    for (int i = 10; i >= 0; i--) begin
      if (text[i*8 +: 8] != 8'h00 || line.size() != 0) line.push_back(text[i*8 +: 8]);
    end
    foreach (line[i]) begin
      e.ch   = line[i];
      e.last = (i == line.size() - 1);
      pending_chars.push_back(e);
    end
  endfunction

  function automatic dir_row_t row_req(input logic [sdaf_pkg::COUNT_W-1:0] c,
                                       input logic [87:0] t);
    dir_row_t r;
    r        = '0;
    r.count  = c;
    r.text   = t;
    return r;
  endfunction

  function automatic dir_row_t row_cfg(input logic idx,
                                       input logic [sdaf_pkg::SCALE_W-1:0] v);
    dir_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = v;
    return r;
  endfunction

  // Offer one request after a random gap; noise sits on the data while idle.
  // Record the expectation at the edge where the request is taken.
  task automatic send_count(input logic [sdaf_pkg::COUNT_W-1:0] c,
                            input logic [87:0] text);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    for (int i = 0; i < gap; i++) begin
      @(negedge clk);
      in_push        <= 1'b0;
      in_count_value <= $urandom;
    end
    @(negedge clk);
    in_push        <= 1'b1;
    in_count_value <= c;
    do @(posedge clk); while (in_full);
    if (text != '0) expect_text(text);
    else predict_chars(c);
  endtask

  // Stop offering and wait until every expected character has been popped
  task automatic drain_requests;
    @(negedge clk);
    in_push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // Write a register with the block idle; keep the shadow copy in step
  task automatic write_reg(input logic idx, input logic [sdaf_pkg::SCALE_W-1:0] val);
    drain_requests();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == sdaf_pkg::CFG_SCALE_DIVISOR) scale_shadow = val;
    else crlf_shadow = val[0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= sdaf_pkg::SCALE_W'($urandom);
  endtask

  // Random count: full range, small values, values near a multiple of the
  // scale, powers of ten and the extremes of the field
  function automatic logic [sdaf_pkg::COUNT_W-1:0] rand_count();
    logic [sdaf_pkg::COUNT_W-1:0] v;
    logic [sdaf_pkg::COUNT_W-1:0] p;
    int                           divisor;
    divisor = (scale_shadow == '0) ? 1 : int'(scale_shadow);
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: v = $urandom_range(0, 99);
      3: v = sdaf_pkg::COUNT_W'(divisor) * $urandom_range(0, 300)
             + $urandom_range(0, 2) - 1;
      4: begin
        p = 1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        v = p - $urandom_range(0, 1);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h8000_0001;
          default: v = '0;
        endcase
      end
    endcase
    if ($urandom_range(0, 1) == 1) v = ~v + 1'b1;
    return v;
  endfunction

  // Result side: pop with random waits, in stretches with no waits at all,
  // and once hold off for a long spell so the block fills and stalls input
  initial begin : result_side
    int        gap;
    bit        rx_busy;
    char_exp_t want;
    rx_busy = 1'b1;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_wanted && !hold_done) begin
        @(negedge clk);
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      if (chars_taken % 40 == 39) rx_busy = ~rx_busy;
      gap = rx_busy ? $urandom_range(0, 12) : 0;
      for (int i = 0; i < gap; i++) begin
        @(negedge clk);
        out_pop <= 1'b0;
      end
      @(negedge clk);
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %02h", out_ascii_char));
      end else begin
        want = pending_chars.pop_front();
        if (out_ascii_char !== want.ch) begin
          report_mismatch($sformatf("ascii_char got %02h want %02h",
                                    out_ascii_char, want.ch));
        end
        if (out_last_char !== want.last) begin
          report_mismatch($sformatf("last_char got %b want %b",
                                    out_last_char, want.last));
        end
      end
      chars_taken++;
    end
  end

  // Request side and overall sequencing
  initial begin : request_side
    logic [sdaf_pkg::SCALE_W-1:0] phase_scale[RAND_PHASES];
    logic                         phase_crlf[RAND_PHASES];
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_count_value = '0;
    out_pop        = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = sdaf_pkg::CFG_SCALE_DIVISOR;
    cfg_wdata      = '0;
    scale_shadow   = 16'd1;
    crlf_shadow    = 1'b0;
    mismatch_count = 0;
    chars_taken    = 0;
    tx_gap_max     = 12;
    hold_wanted    = 1'b0;
    hold_done      = 1'b0;

    // Directed table. Typed rows run with line end off; a zero divisor
    // passes the count unscaled.
    dir_tab[0]  = row_req(32'd0, "0");
    dir_tab[1]  = row_req(32'd1, "1");
    dir_tab[2]  = row_req(-32'sd1, "-1");
    dir_tab[3]  = row_req(32'd9, "9");
    dir_tab[4]  = row_req(-32'sd10, "-10");
    dir_tab[5]  = row_req(32'h7FFF_FFFF, "2147483647");
    dir_tab[6]  = row_req(32'h8000_0000, "-2147483648");
    dir_tab[7]  = row_req(32'd1000000000, "1000000000");
    dir_tab[8]  = row_req(-32'sd999999999, "-999999999");
    dir_tab[9]  = row_req(32'h5A5A_A5A5, '0);
    dir_tab[10] = row_cfg(sdaf_pkg::CFG_SCALE_DIVISOR, 16'd0);
    dir_tab[11] = row_req(-32'sd123, "-123");
    dir_tab[12] = row_req(32'hA5A5_5A5A, '0);
    dir_tab[13] = row_cfg(sdaf_pkg::CFG_APPEND_LINE_END, 16'd1);
    dir_tab[14] = row_req(32'd0, '0);
    dir_tab[15] = row_cfg(sdaf_pkg::CFG_SCALE_DIVISOR, 16'hFFFF);
    // Zero and non-zero quotients, including a negative count truncating to zero
    dir_tab[16] = row_req(32'd65534, '0);
    dir_tab[17] = row_req(-32'sd65534, '0);
    dir_tab[18] = row_req(-32'sd65535, '0);
    dir_tab[19] = row_req(32'h7FFF_FFFF, '0);
    dir_tab[20] = row_req(32'h8000_0000, '0);
    dir_tab[21] = row_cfg(sdaf_pkg::CFG_SCALE_DIVISOR, 16'd10);
    dir_tab[22] = row_req(-32'sd9, '0);
    dir_tab[23] = row_req(32'd123456789, '0);
    // Only bit 0 of the line-end register counts
    dir_tab[24] = row_cfg(sdaf_pkg::CFG_APPEND_LINE_END, 16'hFFFE);

    // Random phases: scale and line end for each, extremes among them
    phase_scale = '{16'd1, 16'hFFFF, 16'd0, 16'd3, 16'd360, 16'd0, 16'd10, 16'd1};
    phase_crlf  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    phase_scale[5] = sdaf_pkg::SCALE_W'($urandom);
    phase_crlf[5]  = 1'($urandom_range(0, 1));

    // Hold reset, then release it
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].is_cfg) write_reg(dir_tab[r].idx, dir_tab[r].val);
      else send_count(dir_tab[r].count, dir_tab[r].text);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      // Random upper bits on the line-end write must be ignored
      write_reg(sdaf_pkg::CFG_SCALE_DIVISOR, phase_scale[ph]);
      write_reg(sdaf_pkg::CFG_APPEND_LINE_END, {15'($urandom), phase_crlf[ph]});
      tx_gap_max = (ph % 2 == 0) ? 12 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Ask the result side for its long hold-off early in the first phase
        if (ph == 0 && n == 5) hold_wanted = 1'b1;
        send_count(rand_count(), '0);
      end
    end

    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0) begin
      report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
    end
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/sdaf_pkg.sv
rtl/sdaf_front.sv
rtl/sdaf_queue.sv
rtl/sdaf_back.sv
rtl/signed_decimal_ascii_formatter_unit.sv
tb/sv/tb_signed_decimal_ascii_formatter_unit.sv
